>>> rtl/core/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Types and codes shared by the retransmission table modules.
// ----------------------------------------------------------------------------
package crt_pkg;

   localparam logic [1:0] REQ_SENT = 2'd0;
   localparam logic [1:0] REQ_RECV = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   localparam logic [1:0] KIND_CON = 2'd0;
   localparam logic [1:0] KIND_NON = 2'd1;
   localparam logic [1:0] KIND_ACK = 2'd2;
   localparam logic [1:0] KIND_RST = 2'd3;

   localparam logic [3:0] EV_ACCEPTED    = 4'd0;
   localparam logic [3:0] EV_UNSUPPORTED = 4'd1;
   localparam logic [3:0] EV_DUPLICATE   = 4'd2;
   localparam logic [3:0] EV_FULL        = 4'd3;
   localparam logic [3:0] EV_IGNORED     = 4'd4;
   localparam logic [3:0] EV_REMOVED     = 4'd5;
   localparam logic [3:0] EV_RESEND      = 4'd6;
   localparam logic [3:0] EV_RESEND_GIVE = 4'd7;
   localparam logic [3:0] EV_GIVE_UP     = 4'd8;
   localparam logic [3:0] EV_SCAN_DONE   = 4'd9;

   localparam logic [1:0] CSR_ACK_TIMEOUT    = 2'd0;
   localparam logic [1:0] CSR_MAX_TRIES      = 2'd1;
   localparam logic [1:0] CSR_TRANSPORT_MASK = 2'd2;

   localparam logic [15:0] ACK_TIMEOUT_RST = 16'd2000;
   localparam logic [3:0]  MAX_TRIES_RST   = 4'd4;
   localparam logic [7:0]  TRANSPORT_RST   = 8'hFF;
   localparam logic [9:0]  RND_SCALE       = 10'd1000;
   localparam logic [3:0]  TRIES_SAT       = 4'hF;

   typedef struct packed {
      logic [15:0] msg_id;
      logic [7:0]  transport;
      logic [15:0] tag;
      logic [31:0] stamp;
      logic [15:0] timeout;
      logic [3:0]  tries;
   } entry_type;

   typedef struct packed {
      logic start;
      logic chk;
      logic rd;
      logic ld;
      logic dec;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_end;
      logic dec_emit;
      logic out_busy;
   } status_type;

endpackage

>>> rtl/core/crt_ram.sv
// ----------------------------------------------------------------------------
// crt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module crt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/crt_ctrl.sv
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer: request intake, table pass one entry at a time, final result.
// ----------------------------------------------------------------------------
module crt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  crt_pkg::status_type status,
   output crt_pkg::cmd_type    cmd
);
   import crt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHK, ST_RD, ST_LD, ST_DEC, ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      stall_in  = stall_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stall_ff) begin
               cmd.start = 1'b1;
               state_in  = ST_CHK;
               stall_in  = 1'b1;
            end
         end
         ST_CHK: begin
            cmd.chk  = 1'b1;
            state_in = status.need_scan ? ST_RD : ST_FIN;
         end
         ST_RD: begin
            if (status.scan_end) begin
               state_in = ST_FIN;
            end else begin
               cmd.rd   = 1'b1;
               state_in = ST_LD;
            end
         end
         ST_LD: begin
            cmd.ld   = 1'b1;
            state_in = ST_DEC;
         end
         ST_DEC: begin
            if (!(status.dec_emit && status.out_busy)) begin
               cmd.dec  = 1'b1;
               state_in = ST_RD;
            end
         end
         ST_FIN: begin
            if (!status.out_busy) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
               stall_in = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;
endmodule

>>> rtl/core/crt_datapath.sv
// ----------------------------------------------------------------------------
// crt_datapath
// Request registers, millisecond clock, table RAM with compacting pass,
// backoff compare and result register.
// ----------------------------------------------------------------------------
module crt_datapath #(
   parameter int ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  crt_pkg::cmd_type    cmd,
   output crt_pkg::status_type status,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic [1:0]          req_type,
   input  logic [7:0]          req_transport,
   input  logic [1:0]          req_msg_kind,
   input  logic [15:0]         req_msg_id,
   input  logic                req_code_empty,
   input  logic [15:0]         req_buffer_tag,
   input  logic [7:0]          req_random_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_event_res,
   output logic [15:0]         rsp_msg_id_res,
   output logic [7:0]          rsp_transport_res,
   output logic [15:0]         rsp_buffer_tag_res,
   output logic                rsp_return_pdu,
   output logic [3:0]          rsp_tries,
   output logic                rsp_last
);
   import crt_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int EW = $bits(entry_type);

   logic [15:0]   ack_timeout_ff;
   logic [3:0]    max_tries_ff;
   logic [7:0]    mask_ff;
   logic [31:0]   now_ff;
   logic [CW-1:0] count_ff, rp_ff, wp_ff;

   logic [1:0]    type_ff, kind_ff;
   logic [7:0]    tr_ff, rnd_ff;
   logic [15:0]   id_ff, tag_ff, tmo_new_ff;
   logic          empty_ff, dup_ff, found_ff;
   entry_type     cap_ff, ent_ff;
   logic [31:0]   elapsed_ff, limit_ff;

   logic          rsp_valid_ff;
   logic [3:0]    ev_ff, tries_out_ff;
   logic [15:0]   id_out_ff, tag_out_ff;
   logic [7:0]    tr_out_ff;
   logic          rp_out_ff, last_ff;

   logic [EW-1:0] rd_word;
   entry_type     rd_ent, wr_ent;
   logic          we;
   logic [IW-1:0] waddr;

   logic          tr_ok, sent_ok, recv_ok, full, match, resend, give;
   logic [3:0]    new_tries;
   logic [17:0]   rnd_prod;
   logic [16:0]   tmo_sum;

   logic          emit;
   logic [3:0]    ev_in, tries_in;
   logic [15:0]   id_in, tag_in;
   logic [7:0]    tr_in;
   logic          rp_in;

   assign rd_ent   = entry_type'(rd_word);
   assign tr_ok    = (mask_ff & tr_ff) != 8'd0;
   assign sent_ok  = tr_ok && (kind_ff == KIND_CON);
   assign recv_ok  = tr_ok && ((kind_ff == KIND_ACK) || (kind_ff == KIND_RST));
   assign full     = count_ff >= CW'(ENTRIES);
   assign match    = (ent_ff.msg_id == id_ff) && (ent_ff.transport == tr_ff);
   assign resend   = elapsed_ff >= limit_ff;
   assign new_tries = (resend && (ent_ff.tries != TRIES_SAT)) ? ent_ff.tries + 4'd1
                                                             : ent_ff.tries;
   assign give     = new_tries >= max_tries_ff;
   assign rnd_prod = 18'(RND_SCALE) * 18'(rnd_ff);
   assign tmo_sum  = 17'(ack_timeout_ff) + 17'(rnd_prod[17:8]);

   assign status.need_scan = (type_ff == REQ_SENT && sent_ok) ||
                             (type_ff == REQ_RECV && recv_ok) || (type_ff == REQ_TICK);
   assign status.scan_end  = rp_ff == count_ff;
   assign status.dec_emit  = (type_ff == REQ_TICK) && (resend || give);
   assign status.out_busy  = rsp_valid_ff && rsp_stall;

   always_comb begin
      we     = 1'b0;
      waddr  = wp_ff[IW-1:0];
      wr_ent = ent_ff;
      if (cmd.dec) begin
         priority case (type_ff)
            REQ_RECV: we = found_ff || !match;
            REQ_TICK: begin
               we = !give;
               wr_ent.tries = new_tries;
               if (resend) begin
                  wr_ent.stamp = now_ff;
               end
            end
            default: we = 1'b0;
         endcase
      end else if (cmd.fin && type_ff == REQ_SENT && sent_ok && !dup_ff && !full) begin
         we     = 1'b1;
         waddr  = count_ff[IW-1:0];
         wr_ent = '{msg_id: id_ff, transport: tr_ff, tag: tag_ff, stamp: now_ff,
                    timeout: tmo_new_ff, tries: 4'd0};
      end
   end

   crt_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (EW'(wr_ent)),
      .rd_en   (cmd.rd),
      .rd_addr (rp_ff[IW-1:0]),
      .rd_data (rd_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff <= ACK_TIMEOUT_RST;
         max_tries_ff   <= MAX_TRIES_RST;
         mask_ff        <= TRANSPORT_RST;
         now_ff         <= '0;
         count_ff       <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_ACK_TIMEOUT:    ack_timeout_ff <= csr_wdata;
               CSR_MAX_TRIES:      max_tries_ff   <= csr_wdata[3:0];
               CSR_TRANSPORT_MASK: mask_ff        <= csr_wdata[7:0];
               default:            ;
            endcase
         end
         if (cmd.chk && type_ff == REQ_TICK) begin
            now_ff <= now_ff + 32'd1;
         end
         if (cmd.fin) begin
            if (type_ff == REQ_SENT) begin
               if (sent_ok && !dup_ff && !full) begin
                  count_ff <= CW'(count_ff + 1'b1);
               end
            end else if (type_ff == REQ_TICK || (type_ff == REQ_RECV && recv_ok)) begin
               count_ff <= wp_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         type_ff  <= req_type;
         tr_ff    <= req_transport;
         kind_ff  <= req_msg_kind;
         id_ff    <= req_msg_id;
         empty_ff <= req_code_empty;
         tag_ff   <= req_buffer_tag;
         rnd_ff   <= req_random_byte;
         rp_ff    <= '0;
         wp_ff    <= '0;
         dup_ff   <= 1'b0;
         found_ff <= 1'b0;
      end
      if (cmd.chk) begin
         tmo_new_ff <= tmo_sum[16] ? 16'hFFFF : tmo_sum[15:0];
      end
      if (cmd.ld) begin
         ent_ff     <= rd_ent;
         elapsed_ff <= now_ff - rd_ent.stamp;
         limit_ff   <= 32'(rd_ent.timeout) << rd_ent.tries;
      end
      if (cmd.dec) begin
         rp_ff <= CW'(rp_ff + 1'b1);
         if (we) begin
            wp_ff <= CW'(wp_ff + 1'b1);
         end
         if (type_ff == REQ_SENT && match) begin
            dup_ff <= 1'b1;
         end
         if (type_ff == REQ_RECV && !found_ff && match) begin
            found_ff <= 1'b1;
            cap_ff   <= ent_ff;
         end
      end
   end

   always_comb begin
      emit     = cmd.fin || (cmd.dec && status.dec_emit);
      ev_in    = EV_IGNORED;
      id_in    = '0;
      tr_in    = '0;
      tag_in   = '0;
      rp_in    = 1'b0;
      tries_in = '0;
      if (cmd.dec) begin
         ev_in    = resend ? (give ? EV_RESEND_GIVE : EV_RESEND) : EV_GIVE_UP;
         id_in    = ent_ff.msg_id;
         tr_in    = ent_ff.transport;
         tag_in   = ent_ff.tag;
         tries_in = new_tries;
      end else begin
         unique case (type_ff)
            REQ_SENT: begin
               ev_in  = !sent_ok ? EV_UNSUPPORTED : dup_ff ? EV_DUPLICATE
                      : full ? EV_FULL : EV_ACCEPTED;
               id_in  = id_ff;
               tr_in  = tr_ff;
               tag_in = tag_ff;
            end
            REQ_RECV: begin
               if (found_ff) begin
                  ev_in    = EV_REMOVED;
                  id_in    = cap_ff.msg_id;
                  tr_in    = cap_ff.transport;
                  tag_in   = cap_ff.tag;
                  rp_in    = empty_ff;
                  tries_in = cap_ff.tries;
               end else begin
                  id_in = id_ff;
                  tr_in = tr_ff;
               end
            end
            REQ_TICK: ev_in = EV_SCAN_DONE;
            default:  ev_in = EV_IGNORED;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         ev_ff        <= ev_in;
         id_out_ff    <= id_in;
         tr_out_ff    <= tr_in;
         tag_out_ff   <= tag_in;
         rp_out_ff    <= rp_in;
         tries_out_ff <= tries_in;
         last_ff      <= cmd.fin;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_res      = ev_ff;
   assign rsp_msg_id_res     = id_out_ff;
   assign rsp_transport_res  = tr_out_ff;
   assign rsp_buffer_tag_res = tag_out_ff;
   assign rsp_return_pdu     = rp_out_ff;
   assign rsp_tries          = tries_out_ff;
   assign rsp_last           = last_ff;
endmodule

>>> rtl/core/confirmable_retransmit_table_unit.sv
// Sequence: a request's final result follows the table pass; each entry goes through a RAM read,
// a load and a decide-and-write-back state in turn, and a request with no search skips the pass.
// Throughput: one request at a time; the next is taken in the cycle after the final result is
// registered. The table pass, one entry at a time, sets this; result stalls add to it.
// Reset (synchronous): clock and entry count clear, configuration registers return to defaults
// and the result valid clears; no RAM clearing pass.
// ----------------------------------------------------------------------------
// confirmable_retransmit_table_unit
// Confirmable message table with exponential backoff retransmission.
// ----------------------------------------------------------------------------
module confirmable_retransmit_table_unit #(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_transport,
   input  logic [1:0]  req_msg_kind,
   input  logic [15:0] req_msg_id,
   input  logic        req_code_empty,
   input  logic [15:0] req_buffer_tag,
   input  logic [7:0]  req_random_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_event_res,
   output logic [15:0] rsp_msg_id_res,
   output logic [7:0]  rsp_transport_res,
   output logic [15:0] rsp_buffer_tag_res,
   output logic        rsp_return_pdu,
   output logic [3:0]  rsp_tries,
   output logic        rsp_last
);
   import crt_pkg::*;

   cmd_type    cmd;
   status_type status;

   crt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   crt_datapath #(.ENTRIES(ENTRIES)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_type           (req_type),
      .req_transport      (req_transport),
      .req_msg_kind       (req_msg_kind),
      .req_msg_id         (req_msg_id),
      .req_code_empty     (req_code_empty),
      .req_buffer_tag     (req_buffer_tag),
      .req_random_byte    (req_random_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_msg_id_res     (rsp_msg_id_res),
      .rsp_transport_res  (rsp_transport_res),
      .rsp_buffer_tag_res (rsp_buffer_tag_res),
      .rsp_return_pdu     (rsp_return_pdu),
      .rsp_tries          (rsp_tries),
      .rsp_last           (rsp_last)
   );
endmodule

>>> rtl/core/crt_checker.sv
// ----------------------------------------------------------------------------
// crt_checker
// Port-level checks on the result channel of the retransmission table.
// ----------------------------------------------------------------------------
module crt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_event_res,
   input logic [15:0] rsp_msg_id_res,
   input logic        rsp_last
);
   import crt_pkg::*;

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_stalled_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res))
      else $error("stalled result changed");

   a_mid_is_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_event_res == EV_RESEND ||
         rsp_event_res == EV_RESEND_GIVE || rsp_event_res == EV_GIVE_UP))
      else $error("non-final result is not a scan result");

   a_scan_done_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_SCAN_DONE |-> rsp_last && rsp_msg_id_res == 16'd0)
      else $error("scan done result malformed");
endmodule

bind confirmable_retransmit_table_unit crt_checker u_crt_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_event_res  (rsp_event_res),
   .rsp_msg_id_res (rsp_msg_id_res),
   .rsp_last       (rsp_last)
);
